@@ rtl/core/bse_pkg.sv @@
// ============================================================================
// bse_pkg: shared types and constants of the BMP LSB embedder
// Item layout, preamble constants and the preamble bit lookup.
// ============================================================================
`default_nettype none

package bse_pkg;

    localparam int POS_W         = 32;
    localparam int LEN_W         = 28;
    localparam int BYTE_W        = 8;
    localparam int PREAMBLE_BITS = 112;
    localparam int PRE_IDX_W     = 7;

    // '#', '*', 32-bit value 4, ".txt"; the 32-bit length follows it.
    localparam logic [79:0] PRE_FIXED = 80'h232A_0000_0004_2E74_7874;

    localparam logic MODE_IMAGE  = 1'b0;
    localparam logic MODE_SECRET = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data;
    } t_item;

    // Preamble bit k, counted from the most significant bit of the preamble.
    function automatic logic preamble_bit(input logic [PRE_IDX_W-1:0] k,
                                          input logic [LEN_W-1:0]     len);
        logic [PREAMBLE_BITS-1:0] vec;
        logic [PRE_IDX_W-1:0]     idx;
        vec = {PRE_FIXED, 4'b0000, len};
        idx = PRE_IDX_W'(PREAMBLE_BITS - 1) - k;
        return vec[idx];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bse_in_stage.sv @@
// ============================================================================
// bse_in_stage: input register
// Holds one accepted request until the embedding stage takes it.
// ============================================================================
`default_nettype none

module bse_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bse_pkg::t_item i_item,
    output logic               o_valid,
    output bse_pkg::t_item     o_item,
    input  wire logic          i_take
);

    logic           r_valid;
    bse_pkg::t_item r_item;

    // The stage can refill in the same cycle that its content moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bse_embed.sv @@
// ============================================================================
// bse_embed: position tracking, LSB replacement and result register
// Decides the embedded bit for each image byte and registers the result.
// ============================================================================
`default_nettype none

module bse_embed #(
    parameter int HEADER_BYTES = 54
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [bse_pkg::LEN_W-1:0]   i_cfg_wr_data,
    input  wire logic                        i_valid,
    input  wire bse_pkg::t_item              i_item,
    output logic                             o_take,
    output logic                             o_out_valid,
    output logic [bse_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_underrun,
    input  wire logic                        i_out_ready
);

    localparam int SEC_START = HEADER_BYTES + bse_pkg::PREAMBLE_BITS;
    localparam logic [bse_pkg::POS_W-1:0] PRE_START_W = bse_pkg::POS_W'(HEADER_BYTES);
    localparam logic [bse_pkg::POS_W-1:0] SEC_START_W = bse_pkg::POS_W'(SEC_START);
    localparam logic [bse_pkg::PRE_IDX_W-1:0] PRE_PHASE = bse_pkg::PRE_IDX_W'(HEADER_BYTES);
    localparam logic [2:0] SEC_PHASE = 3'(SEC_START);

    logic [bse_pkg::LEN_W-1:0]  r_len;
    logic [bse_pkg::POS_W-1:0]  r_sec_end;
    logic [bse_pkg::POS_W-1:0]  r_pos;
    logic [bse_pkg::BYTE_W-1:0] r_buf;
    logic                       r_buf_valid;
    logic [bse_pkg::BYTE_W-1:0] r_shift;
    logic                       r_out_valid;
    logic [bse_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_underrun;

    logic                       out_free;
    logic                       take_image;
    logic                       in_pre;
    logic                       in_sec;
    logic                       boundary;
    logic [bse_pkg::PRE_IDX_W-1:0] pre_k;
    logic [bse_pkg::BYTE_W-1:0] cur_shift;
    logic                       emb_bit;
    logic [bse_pkg::BYTE_W-1:0] n_out_byte;
    logic                       n_underrun;
    logic [bse_pkg::BYTE_W-1:0] n_shift;

    // Secret loads never produce a result, so they move on regardless of
    // the output side.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_take     = i_valid && ((i_item.mode == bse_pkg::MODE_SECRET) || out_free);
    assign take_image = o_take && (i_item.mode == bse_pkg::MODE_IMAGE);

    always_comb begin
        in_pre    = (r_pos >= PRE_START_W) && (r_pos < SEC_START_W);
        in_sec    = (r_pos >= SEC_START_W) && (r_pos < r_sec_end);
        boundary  = (r_pos[2:0] == SEC_PHASE);
        pre_k     = r_pos[bse_pkg::PRE_IDX_W-1:0] - PRE_PHASE;
        cur_shift = r_shift;
        if (boundary) begin
            cur_shift = r_buf_valid ? r_buf : '0;
        end
        n_shift    = {cur_shift[bse_pkg::BYTE_W-2:0], 1'b0};
        emb_bit    = 1'b0;
        n_out_byte = i_item.data;
        n_underrun = 1'b0;
        if (in_pre) begin
            emb_bit    = bse_pkg::preamble_bit(pre_k, r_len);
            n_out_byte = {i_item.data[bse_pkg::BYTE_W-1:1], emb_bit};
        end else if (in_sec) begin
            emb_bit    = cur_shift[bse_pkg::BYTE_W-1];
            n_out_byte = {i_item.data[bse_pkg::BYTE_W-1:1], emb_bit};
            n_underrun = boundary && !r_buf_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_sec_end   <= SEC_START_W;
            r_pos       <= '0;
            r_buf       <= '0;
            r_buf_valid <= 1'b0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len     <= i_cfg_wr_data;
                r_sec_end <= SEC_START_W + {1'b0, i_cfg_wr_data, 3'b000};
            end
            if (o_take && (i_item.mode == bse_pkg::MODE_SECRET)) begin
                r_buf       <= i_item.data;
                r_buf_valid <= 1'b1;
            end
            if (take_image) begin
                if (in_sec) begin
                    r_shift <= n_shift;
                    if (boundary) begin
                        r_buf_valid <= 1'b0;
                    end
                end
                if (r_pos != '1) begin
                    r_pos <= r_pos + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_image) begin
            r_out_byte <= n_out_byte;
            r_underrun <= n_underrun;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_underrun  = r_underrun;

endmodule

`default_nettype wire

@@ rtl/core/bmp_lsb_stego_embedder.sv @@
// An image byte request passes through the input register into the output register,
// from which it is shown on the output.
// Throughput: one request per cycle while the output is not stalled, image bytes
// and secret loads alike; the input and output registers turn over once per cycle.
// Secret loads produce no result and move on even while the output is stalled.
// Reset (i_rst_n low, synchronous) clears the byte position, the secret buffer,
// the length register and both valid flags.
// ============================================================================
// bmp_lsb_stego_embedder: LSB embedder for a BMP byte stream
// Replaces the least significant bit of image bytes with a preamble and a
// secret payload streamed in through a one-byte holding buffer.
// ============================================================================
`default_nettype none

module bmp_lsb_stego_embedder #(
    parameter int HEADER_BYTES = 54
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: secret length in bytes, written on i_cfg_wr_en.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [27:0] i_cfg_wr_data,
    // Input requests.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] mode (0 image, 1 secret load)
    // Result requests.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tuser    // [0] underrun
);

    bse_pkg::t_item in_item;
    bse_pkg::t_item st_item;
    logic           st_valid;
    logic           st_take;

    // The request is packed into one struct: mode selects whether the byte
    // is image data or the next secret byte for the holding buffer.
    assign in_item.mode = s_axis_tuser;
    assign in_item.data = s_axis_tdata;

    // Input register: decouples the upstream handshake from the embedding
    // stage and lets a new request enter every cycle while the embedding stage takes them.
    bse_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (st_take)
    );

    // Embedding stage: tracks the byte position, chooses between header
    // pass-through, preamble bits, secret bits and trailing pass-through,
    // and holds the finished result in the output register.
    bse_embed #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_embed (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (st_valid),
        .i_item        (st_item),
        .o_take        (st_take),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (m_axis_tdata),
        .o_underrun    (m_axis_tuser),
        .i_out_ready   (m_axis_tready)
    );

endmodule

`default_nettype wire

@@ rtl/core/bse_checker.sv @@
// ============================================================================
// bse_port_checker: port-level checks for the BMP LSB embedder
// Observes the top-level ports only and is bound to every instance.
// ============================================================================
`default_nettype none

module bse_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // An underrun embeds a zero bit on the boundary byte.
    a_underrun_zero_lsb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[0] == 1'b0))
        else $error("underrun result carries a nonzero LSB");

    // The input side only backs up when the output side is stalled.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

    // Nothing is shown on the output right after reset.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

endmodule

bind bmp_lsb_stego_embedder bse_port_checker u_bse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
